// ----- rtl/htsk_pkg.sv -----
// Package for the heater thermostat with setpoint keys.
// Holds widths, limits, register indexes and the seven-segment table.
// Depends on nothing else.
`default_nettype none

package htsk_pkg;

  localparam int STEP_W   = 10;
  localparam int DUTY_W   = 10;
  localparam int SAMPLE_W = 10;
  localparam int SP_W     = 14;
  localparam int SEG_W    = 7;
  localparam int CFG_ADDR_W = 2;

  localparam logic [SP_W-1:0]   SETPOINT_RESET = 14'd4150;
  localparam logic [SP_W-1:0]   SETPOINT_MAX   = 14'd9999;
  localparam logic [DUTY_W-1:0] DUTY_MAX       = 10'd1023;
  localparam logic [11:0]       TEMP_OFFSET    = 12'd150;

  localparam logic [STEP_W-1:0] COARSE_RESET = 10'd100;
  localparam logic [STEP_W-1:0] FINE_RESET   = 10'd10;
  localparam logic [STEP_W-1:0] HEATER_RESET = 10'd10;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_COARSE_STEP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FINE_STEP   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEATER_STEP = 2'd2;

  // Reciprocal constants for division by ten; each is exact over the
  // range of the value it is applied to.
  localparam logic [15:0] RECIP10_SP = 16'd52429;  // shift 19, up to 9999
  localparam logic [7:0]  RECIP10_Q1 = 8'd205;     // shift 11, up to 999
  localparam logic [6:0]  RECIP10_Q2 = 7'd103;     // shift 10, up to 99

  // Segment pattern of one decimal digit, bit 0 is segment a.
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/heater_thermostat_with_setpoint_keys.sv -----
// Top level of the heater thermostat with setpoint keys.
// Updates the setpoint from key edges, steps the heater duty and splits the
// setpoint into seven-segment digits. Depends on htsk_pkg.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   keys, temp_sample, cooler_sample
//  out      output     out_valid / out_stall duties, setpoint, segment digits
//  cfg      input      cfg_we                cfg_addr, cfg_wdata
//
// One item is accepted per cycle while in_stall is low; each result passes the
// first stage, the three divide-by-ten steps of the digit split and the output register.
// Setpoint and heater duty each loop through a single register, so the rate
// stays at one item a cycle. Reset (synchronous, rst_n low) restores the
// step registers, the setpoint, the heater duty and empties the pipeline.
// A stall on the output holds the result; earlier stages keep filling until
// the pipeline is full, and only then is in_stall raised.
`default_nettype none

module heater_thermostat_with_setpoint_keys (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_key_up_coarse,
  input  wire logic                           in_key_down_coarse,
  input  wire logic                           in_key_up_fine,
  input  wire logic                           in_key_down_fine,
  input  wire logic [htsk_pkg::SAMPLE_W-1:0]  in_temp_sample,
  input  wire logic [htsk_pkg::SAMPLE_W-1:0]  in_cooler_sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [htsk_pkg::DUTY_W-1:0]         out_heater_duty,
  output logic [htsk_pkg::DUTY_W-1:0]         out_cooler_duty,
  output logic [htsk_pkg::SP_W-1:0]           out_setpoint_value,
  output logic [htsk_pkg::SEG_W-1:0]          out_seg_thousands,
  output logic [htsk_pkg::SEG_W-1:0]          out_seg_hundreds,
  output logic [htsk_pkg::SEG_W-1:0]          out_seg_tens,
  output logic [htsk_pkg::SEG_W-1:0]          out_seg_units,
  input  wire logic                           cfg_we,
  input  wire logic [htsk_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [htsk_pkg::STEP_W-1:0]    cfg_wdata
);

  import htsk_pkg::*;

  // Configuration registers.
  logic [STEP_W-1:0] coarse_step_r, fine_step_r, heater_step_r;

  // State.
  logic [3:0]        prev_keys_r;
  logic [SP_W-1:0]   setpoint_r;   // also the setpoint of the first stage
  logic [DUTY_W-1:0] heater_r;     // also the duty of the third stage

  // Pipeline valids.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic move1, move2, move3, move4, in_acc;

  // Stage payloads.
  logic signed [11:0] temp1_r, temp2_r;
  logic [SAMPLE_W-1:0] cool1_r, cool2_r, cool3_r, cool4_r;
  logic [SP_W-1:0]     sp2_r, sp3_r, sp4_r;
  logic [9:0]          q1_2_r, q1_3_r;
  logic [6:0]          q2_3_r, q2_4_r;
  logic [3:0]          q3_4_r, units3_r, units4_r, tens4_r;
  logic [DUTY_W-1:0]   heat4_r;

  // Output registers.
  logic [DUTY_W-1:0] heater_duty_r, cooler_duty_r;
  logic [SP_W-1:0]   setpoint_out_r;
  logic [SEG_W-1:0]  seg_th_r, seg_hu_r, seg_te_r, seg_un_r;

  // Combinational values.
  logic [3:0]          keys, edges;
  logic signed [15:0]  sp_sum;
  logic [SP_W-1:0]     setpoint_nxt;
  logic [13:0]         temp_x10;
  logic signed [11:0]  temp_nxt;
  logic [29:0]         q1_prod;
  logic [17:0]         q2_prod;
  logic [13:0]         q3_prod;
  logic signed [11:0]  heat_sum;
  logic [DUTY_W-1:0]   heater_nxt;
  logic [SP_W-1:0]     units_full;
  logic [9:0]          tens_full;
  logic [6:0]          hund_full;

  // Handshake: each stage moves on when the next one is empty or moving.
  always_comb begin
    move4    = v4_r && (!out_valid_r || !out_stall);
    move3    = v3_r && (!v4_r || move4);
    move2    = v2_r && (!v3_r || move3);
    move1    = v1_r && (!v2_r || move2);
    in_stall = v1_r && !move1;
    in_acc   = in_valid && !in_stall;
  end

  // Setpoint update from rising key edges, saturated to its range.
  always_comb begin
    keys  = {in_key_down_fine, in_key_up_fine, in_key_down_coarse, in_key_up_coarse};
    edges = keys & ~prev_keys_r;
    sp_sum = $signed({2'b00, setpoint_r});
    if (edges[0]) sp_sum = sp_sum + $signed({6'd0, coarse_step_r});
    if (edges[1]) sp_sum = sp_sum - $signed({6'd0, coarse_step_r});
    if (edges[2]) sp_sum = sp_sum + $signed({6'd0, fine_step_r});
    if (edges[3]) sp_sum = sp_sum - $signed({6'd0, fine_step_r});
    if (sp_sum < 16'sd0) begin
      setpoint_nxt = '0;
    end else if (sp_sum > $signed({2'b00, SETPOINT_MAX})) begin
      setpoint_nxt = SETPOINT_MAX;
    end else begin
      setpoint_nxt = sp_sum[SP_W-1:0];
    end
  end

  // Temperature is sample * 10 / 8 - 150.
  always_comb begin
    temp_x10 = {1'b0, in_temp_sample, 3'b000} + {3'b000, in_temp_sample, 1'b0};
    temp_nxt = $signed({1'b0, temp_x10[13:3]}) - $signed(TEMP_OFFSET);
  end

  // Divide-by-ten steps of the digit split.
  always_comb begin
    q1_prod = setpoint_r * RECIP10_SP;
    q2_prod = q1_2_r * RECIP10_Q1;
    q3_prod = q2_3_r * RECIP10_Q2;
    units_full = sp2_r - ({4'd0, q1_2_r} * 14'd10);
    tens_full  = q1_3_r - ({3'd0, q2_3_r} * 10'd10);
    hund_full  = q2_4_r - ({3'd0, q3_4_r} * 7'd10);
  end

  // Heater duty steps up when the temperature is at or below setpoint / 10.
  always_comb begin
    if (temp2_r <= $signed({2'b00, q1_2_r})) begin
      heat_sum = $signed({2'b00, heater_r}) + $signed({2'b00, heater_step_r});
    end else begin
      heat_sum = $signed({2'b00, heater_r}) - $signed({2'b00, heater_step_r});
    end
    if (heat_sum < 12'sd0) begin
      heater_nxt = '0;
    end else if (heat_sum > $signed({2'b00, DUTY_MAX})) begin
      heater_nxt = DUTY_MAX;
    end else begin
      heater_nxt = heat_sum[DUTY_W-1:0];
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_step_r <= COARSE_RESET;
      fine_step_r   <= FINE_RESET;
      heater_step_r <= HEATER_RESET;
      prev_keys_r   <= '0;
      setpoint_r    <= SETPOINT_RESET;
      heater_r      <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      v4_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_COARSE_STEP: coarse_step_r <= cfg_wdata;
          REG_FINE_STEP:   fine_step_r   <= cfg_wdata;
          REG_HEATER_STEP: heater_step_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        prev_keys_r <= keys;
        setpoint_r  <= setpoint_nxt;
      end
      if (move2) begin
        heater_r <= heater_nxt;
      end
      v1_r        <= in_acc || (v1_r && !move1);
      v2_r        <= move1 || (v2_r && !move2);
      v3_r        <= move2 || (v3_r && !move3);
      v4_r        <= move3 || (v4_r && !move4);
      out_valid_r <= move4 || (out_valid_r && out_stall);
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      temp1_r <= temp_nxt;
      cool1_r <= in_cooler_sample;
    end
    if (move1) begin
      sp2_r   <= setpoint_r;
      q1_2_r  <= q1_prod[28:19];
      temp2_r <= temp1_r;
      cool2_r <= cool1_r;
    end
    if (move2) begin
      sp3_r    <= sp2_r;
      q1_3_r   <= q1_2_r;
      q2_3_r   <= q2_prod[17:11];
      units3_r <= units_full[3:0];
      cool3_r  <= cool2_r;
    end
    if (move3) begin
      sp4_r    <= sp3_r;
      q2_4_r   <= q2_3_r;
      q3_4_r   <= q3_prod[13:10];
      tens4_r  <= tens_full[3:0];
      units4_r <= units3_r;
      heat4_r  <= heater_r;
      cool4_r  <= cool3_r;
    end
    if (move4) begin
      heater_duty_r  <= heat4_r;
      cooler_duty_r  <= cool4_r;
      setpoint_out_r <= sp4_r;
      seg_th_r       <= seg_of(q3_4_r);
      seg_hu_r       <= seg_of(hund_full[3:0]);
      seg_te_r       <= seg_of(tens4_r);
      seg_un_r       <= seg_of(units4_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heater_duty    = heater_duty_r;
  assign out_cooler_duty    = cooler_duty_r;
  assign out_setpoint_value = setpoint_out_r;
  assign out_seg_thousands  = seg_th_r;
  assign out_seg_hundreds   = seg_hu_r;
  assign out_seg_tens       = seg_te_r;
  assign out_seg_units      = seg_un_r;

endmodule

`default_nettype wire

// ----- verif/heater_thermostat_with_setpoint_keys_tb.sv -----
// Testbench for the heater thermostat with setpoint keys.
// Predicts setpoint, heater duty, cooler duty and digit patterns per tick
// and compares every result in order. Depends on htsk_pkg and the top level.
`timescale 1ns / 100ps

module heater_thermostat_with_setpoint_keys_tb;
  import htsk_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0] heater;
    logic [DUTY_W-1:0] cooler;
    logic [SP_W-1:0]   setpoint;
    logic [SEG_W-1:0]  seg_th;
    logic [SEG_W-1:0]  seg_hu;
    logic [SEG_W-1:0]  seg_te;
    logic [SEG_W-1:0]  seg_un;
  } tick_result_t;

  // Holds its own copy of the thermostat state and the expected results.
  class heater_tick_checker;
    tick_result_t expected_q[$];
    logic [3:0]   keys_prev;
    int           sp_now;
    int           heat_now;
    int           coarse;
    int           fine;
    int           heat_step;
    int           failures;
    int           checked;

    function new();
      keys_prev = '0;
      sp_now    = int'(SETPOINT_RESET);
      heat_now  = 0;
      coarse    = int'(COARSE_RESET);
      fine      = int'(FINE_RESET);
      heat_step = int'(HEATER_RESET);
      failures  = 0;
      checked   = 0;
    endfunction

    function void set_steps(int c, int f, int h);
      coarse    = c;
      fine      = f;
      heat_step = h;
    endfunction

    function logic [SEG_W-1:0] digit_segments(int d);
      logic [SEG_W-1:0] p;
      case (d)
        0: p = 7'b0111111;
        1: p = 7'b0000110;
        2: p = 7'b1011011;
        3: p = 7'b1001111;
        4: p = 7'b1100110;
        5: p = 7'b1101101;
        6: p = 7'b1111101;
        7: p = 7'b0000111;
        8: p = 7'b1111111;
        default: p = 7'b1101111;
      endcase
      return p;
    endfunction

    // Key bit order: 0 coarse up, 1 coarse down, 2 fine up, 3 fine down.
    function void predict_tick(logic [3:0] keys, logic [SAMPLE_W-1:0] temp_s,
                               logic [SAMPLE_W-1:0] cool_s);
      logic [3:0]   rise;
      int           deg;
      tick_result_t r;
      rise = keys & ~keys_prev;
      if (rise[0]) sp_now += coarse;
      if (rise[1]) sp_now -= coarse;
      if (rise[2]) sp_now += fine;
      if (rise[3]) sp_now -= fine;
      if (sp_now < 0) sp_now = 0;
      if (sp_now > int'(SETPOINT_MAX)) sp_now = int'(SETPOINT_MAX);
      keys_prev = keys;
      // Below zero degrees the comparison must stay signed.
      deg = (int'(temp_s) * 10) / 8 - int'(TEMP_OFFSET);
      if (deg <= sp_now / 10) heat_now += heat_step;
      else heat_now -= heat_step;
      if (heat_now < 0) heat_now = 0;
      if (heat_now > int'(DUTY_MAX)) heat_now = int'(DUTY_MAX);
      r.heater   = heat_now[DUTY_W-1:0];
      r.cooler   = cool_s;
      r.setpoint = sp_now[SP_W-1:0];
      r.seg_th   = digit_segments(sp_now / 1000);
      r.seg_hu   = digit_segments((sp_now % 1000) / 100);
      r.seg_te   = digit_segments((sp_now % 100) / 10);
      r.seg_un   = digit_segments(sp_now % 10);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t e;
      if (expected_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        failures++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      compare_field("heater_duty", e.heater, got.heater);
      compare_field("cooler_duty", e.cooler, got.cooler);
      compare_field("setpoint_value", e.setpoint, got.setpoint);
      compare_field("seg_thousands", e.seg_th, got.seg_th);
      compare_field("seg_hundreds", e.seg_hu, got.seg_hu);
      compare_field("seg_tens", e.seg_te, got.seg_te);
      compare_field("seg_units", e.seg_un, got.seg_un);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 310;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_key_up_coarse = 1'b0;
  logic in_key_down_coarse = 1'b0;
  logic in_key_up_fine = 1'b0;
  logic in_key_down_fine = 1'b0;
  logic [SAMPLE_W-1:0] in_temp_sample = '0;
  logic [SAMPLE_W-1:0] in_cooler_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DUTY_W-1:0] out_heater_duty;
  logic [DUTY_W-1:0] out_cooler_duty;
  logic [SP_W-1:0] out_setpoint_value;
  logic [SEG_W-1:0] out_seg_thousands;
  logic [SEG_W-1:0] out_seg_hundreds;
  logic [SEG_W-1:0] out_seg_tens;
  logic [SEG_W-1:0] out_seg_units;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [STEP_W-1:0] cfg_wdata = '0;

  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic hold_req = 1'b0;
  int   ticks_sent = 0;
  int   settings_used = 0;

  heater_tick_checker sb = new();

  heater_thermostat_with_setpoint_keys dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_up_coarse   (in_key_up_coarse),
    .in_key_down_coarse (in_key_down_coarse),
    .in_key_up_fine     (in_key_up_fine),
    .in_key_down_fine   (in_key_down_fine),
    .in_temp_sample     (in_temp_sample),
    .in_cooler_sample   (in_cooler_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_heater_duty    (out_heater_duty),
    .out_cooler_duty    (out_cooler_duty),
    .out_setpoint_value (out_setpoint_value),
    .out_seg_thousands  (out_seg_thousands),
    .out_seg_hundreds   (out_seg_hundreds),
    .out_seg_tens       (out_seg_tens),
    .out_seg_units      (out_seg_units),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= rx_idle && ($urandom_range(99) < 36);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    tick_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.heater   = out_heater_duty;
      got.cooler   = out_cooler_duty;
      got.setpoint = out_setpoint_value;
      got.seg_th   = out_seg_thousands;
      got.seg_hu   = out_seg_hundreds;
      got.seg_te   = out_seg_tens;
      got.seg_un   = out_seg_units;
      sb.check_result(got);
    end
  end

  task automatic send_tick(input logic [3:0] keys, input logic [SAMPLE_W-1:0] temp_s,
                           input logic [SAMPLE_W-1:0] cool_s);
    in_valid           <= 1'b1;
    in_key_up_coarse   <= keys[0];
    in_key_down_coarse <= keys[1];
    in_key_up_fine     <= keys[2];
    in_key_down_fine   <= keys[3];
    in_temp_sample     <= temp_s;
    in_cooler_sample   <= cool_s;
    do @(posedge clk); while (in_stall);
    sb.predict_tick(keys, temp_s, cool_s);
    ticks_sent++;
    if (tx_idle) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Lets every outstanding item come out so the block is idle again.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_steps(input int c, input int f, input int h);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_COARSE_STEP;
    cfg_wdata <= c[STEP_W-1:0];
    @(posedge clk);
    cfg_addr  <= REG_FINE_STEP;
    cfg_wdata <= f[STEP_W-1:0];
    @(posedge clk);
    cfg_addr  <= REG_HEATER_STEP;
    cfg_wdata <= h[STEP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_steps(c, f, h);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [3:0] keys;
    int target;
    int t_s;
    int c_step;
    int f_step;
    int h_step;

    keys = '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset steps: single edges, a held key, opposite keys, all keys at once.
    send_tick(4'b0000, 10'd0, 10'd0);
    send_tick(4'b0001, 10'd1023, 10'd1023);
    send_tick(4'b0001, 10'h155, 10'h2AA);
    send_tick(4'b0010, 10'h2AA, 10'h155);
    send_tick(4'b0100, 10'd0, 10'd1);
    send_tick(4'b1000, 10'd1023, 10'd512);
    send_tick(4'b0011, 10'd300, 10'd0);
    send_tick(4'b1100, 10'd640, 10'd1023);
    send_tick(4'b0000, 10'd0, 10'd7);
    send_tick(4'b1111, 10'd1023, 10'd1000);
    settle();

    // Largest steps: drive the setpoint into both limits, heater both clamps.
    write_steps(1023, 1000, 1023);
    send_tick(4'b0101, 10'd0, 10'd3);
    send_tick(4'b0000, 10'd0, 10'd1023);
    send_tick(4'b0101, 10'd1023, 10'd0);
    send_tick(4'b0000, 10'd1023, 10'd99);
    send_tick(4'b0101, 10'd0, 10'd1023);
    send_tick(4'b1010, 10'd0, 10'd0);
    send_tick(4'b0000, 10'd1023, 10'd511);
    send_tick(4'b1010, 10'd1023, 10'd1022);
    send_tick(4'b0000, 10'd0, 10'd256);
    send_tick(4'b1010, 10'd512, 10'd768);
    send_tick(4'b0000, 10'd1023, 10'd1);
    send_tick(4'b1010, 10'd0, 10'd1023);
    send_tick(4'b0000, 10'd0, 10'd0);
    send_tick(4'b1010, 10'd0, 10'd1023);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin c_step = 100;  f_step = 10;   h_step = 10;   end
        1: begin c_step = 1023; f_step = 1023; h_step = 1023; end
        2: begin c_step = 0;    f_step = 0;    h_step = 0;    end
        3: begin c_step = 1000; f_step = 1000; h_step = 1;    end
        default: begin
          c_step = $urandom_range(1023);
          f_step = $urandom_range(1023);
          h_step = $urandom_range(1023);
        end
      endcase
      write_steps(c_step, f_step, h_step);
      // Phase 3 runs with no idling on either side.
      tx_idle = (phase != 3);
      rx_idle = (phase != 3);
      if (phase == 1) begin
        // Long receiver hold-off while items keep coming, to fill the pipeline.
        hold_req = 1'b1;
        tx_idle  = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 40) tx_idle = 1'b1;
        if ($urandom_range(9) == 0) begin
          keys = 4'($urandom_range(15));
        end else begin
          for (int b = 0; b < 4; b++)
            if ($urandom_range(99) < 30) keys[b] = ~keys[b];
        end
        if ($urandom_range(1) == 0) begin
          t_s = $urandom_range(1023);
        end else begin
          // Aim close to the switching point so both heater directions occur.
          target = sb.sp_now / 10 + int'($urandom_range(6)) - 3;
          t_s = ((target + int'(TEMP_OFFSET)) * 8) / 10;
          if (t_s < 0) t_s = 0;
          if (t_s > 1023) t_s = 1023;
        end
        send_tick(keys, t_s[SAMPLE_W-1:0], SAMPLE_W'($urandom_range(1023)));
      end
      settle();
    end

    $display("Sent %0d ticks under %0d step settings; %0d results compared.",
             ticks_sent, settings_used, sb.checked);
    $display("Covered setpoint saturation, held and opposite keys, heater clamps, back-pressure.");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
